>>> rtl/suks_pkg.sv
// ---------------------------------------------------------------------------
// suks_pkg: shared types and codes for the sorted unique key set
// Holds the item structs of both channels, the operation and status codes,
// and the command and status groups between controller and datapath.
// ---------------------------------------------------------------------------
package suks_pkg;

  // Default sizes for the top level parameters.
  localparam int CAPACITY_DEF  = 16;
  localparam int KEY_WIDTH_DEF = 32;

  // Fixed field widths of the channel items.
  localparam int FUNC_W   = 2;
  localparam int KEY_W    = 32;
  localparam int STATUS_W = 2;
  localparam int ENTRY_W  = 5;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FN_SEARCH = 2'd0;
  localparam logic [FUNC_W-1:0] FN_INSERT = 2'd1;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd2;
  localparam logic [FUNC_W-1:0] FN_CHANGE = 2'd3;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ABSENT  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  // Input item.
  typedef struct packed {
    logic        [FUNC_W-1:0] func;
    logic signed [KEY_W-1:0]  key;
    logic signed [KEY_W-1:0]  new_key;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ENTRY_W-1:0]  entry_count;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                load;
    logic                probe_new;
    logic                do_ins;
    logic                do_del;
    logic                res_load;
    logic [STATUS_W-1:0] res_status;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              hit;
    logic              full;
    logic              out_free;
  } dp_stat_t;

endpackage

>>> rtl/suks_dp.sv
// ---------------------------------------------------------------------------
// suks_dp: key cells, compare logic and result register
// A row of cells holds the keys in ascending order. Every cell compares its
// key with the probe key at once; the same flags steer a shift that opens a
// gap for an insert or closes one for a remove.
// ---------------------------------------------------------------------------
module suks_dp #(
  parameter int CAPACITY  = suks_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH = suks_pkg::KEY_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  suks_pkg::in_item_t  in_item,
  input  suks_pkg::dp_cmd_t   cmd,
  output suks_pkg::dp_stat_t  stat,
  input  logic                out_ready,
  output logic                out_valid,
  output suks_pkg::out_item_t out_item
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // Latched item.
  logic [suks_pkg::FUNC_W-1:0] func_r;
  logic signed [KEY_WIDTH-1:0] key_r;
  logic signed [KEY_WIDTH-1:0] new_r;

  // Key cells and fill count.
  logic signed [KEY_WIDTH-1:0] keys_r   [CAPACITY];
  logic signed [KEY_WIDTH-1:0] keys_nxt [CAPACITY];
  logic [CNT_W-1:0]            count_r;
  logic [CNT_W-1:0]            count_nxt;

  // Result register.
  logic                out_valid_r;
  logic                out_valid_nxt;
  suks_pkg::out_item_t out_item_r;

  logic signed [KEY_WIDTH-1:0] probe;
  logic [CAPACITY-1:0]         lt;
  logic [CAPACITY-1:0]         eq;

  // Item latch; keys are sign-extended or cut to KEY_WIDTH bits.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_item.func;
      key_r  <= KEY_WIDTH'(in_item.key);
      new_r  <= KEY_WIDTH'(in_item.new_key);
    end
  end

  assign probe = cmd.probe_new ? new_r : key_r;

  // Per-cell compare against the probe; only held cells take part.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      lt[i] = (CNT_W'(i) < count_r) && (keys_r[i] < probe);
      eq[i] = (CNT_W'(i) < count_r) && (keys_r[i] == probe);
    end
  end

  // Cell shift: cells below the probe keep their key, the rest move.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      keys_nxt[i] = keys_r[i];
      if (cmd.do_ins && !lt[i]) begin
        if (i == 0) begin
          keys_nxt[i] = probe;
        end else if (lt[i-1]) begin
          keys_nxt[i] = probe;
        end else begin
          keys_nxt[i] = keys_r[i-1];
        end
      end else if (cmd.do_del && !lt[i] && (i < CAPACITY - 1)) begin
        keys_nxt[i] = keys_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      keys_r[i] <= keys_nxt[i];
    end
  end

  // Fill count.
  always_comb begin
    count_nxt = count_r;
    if (cmd.do_ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.do_del) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Result register: one item waits here until the receiver takes it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_item_r.status      <= cmd.res_status;
      out_item_r.entry_count <= suks_pkg::ENTRY_W'(count_nxt);
    end
  end

  assign stat.func     = func_r;
  assign stat.hit      = |eq;
  assign stat.full     = (count_r == CAP_CNT);
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

>>> rtl/suks_ctrl.sv
// ---------------------------------------------------------------------------
// suks_ctrl: operation sequencer
// Steps each item through lookup, the new-key check, and the remove and
// insert passes of a change, and decides the status of the result.
// ---------------------------------------------------------------------------
module suks_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  suks_pkg::dp_stat_t stat,
  output suks_pkg::dp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_DEL  = 3'd3;
  localparam logic [2:0] S_INS  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.res_status = suks_pkg::ST_OK;
    in_ready       = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        // The old key has been compared; most operations finish here.
        if (stat.func == suks_pkg::FN_CHANGE && stat.hit) begin
          state_nxt = S_CHK;
        end else if (stat.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
          case (stat.func)
            suks_pkg::FN_SEARCH: begin
              cmd.res_status = stat.hit ? suks_pkg::ST_OK : suks_pkg::ST_ABSENT;
            end
            suks_pkg::FN_INSERT: begin
              if (stat.hit) begin
                cmd.res_status = suks_pkg::ST_PRESENT;
              end else if (stat.full) begin
                cmd.res_status = suks_pkg::ST_FULL;
              end else begin
                cmd.do_ins     = 1'b1;
                cmd.res_status = suks_pkg::ST_OK;
              end
            end
            suks_pkg::FN_REMOVE: begin
              if (stat.hit) begin
                cmd.do_del     = 1'b1;
                cmd.res_status = suks_pkg::ST_OK;
              end else begin
                cmd.res_status = suks_pkg::ST_ABSENT;
              end
            end
            default: begin
              cmd.res_status = suks_pkg::ST_ABSENT;
            end
          endcase
        end
      end
      S_CHK: begin
        // A change is refused when the new key is already held.
        cmd.probe_new = 1'b1;
        if (!stat.hit) begin
          state_nxt = S_DEL;
        end else if (stat.out_free) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = suks_pkg::ST_PRESENT;
          state_nxt      = S_IDLE;
        end
      end
      S_DEL: begin
        cmd.do_del = 1'b1;
        state_nxt  = S_INS;
      end
      S_INS: begin
        cmd.probe_new = 1'b1;
        if (stat.out_free) begin
          cmd.do_ins     = 1'b1;
          cmd.res_load   = 1'b1;
          cmd.res_status = suks_pkg::ST_OK;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/sorted_unique_key_set_top.sv
// ---------------------------------------------------------------------------
// sorted_unique_key_set_top: bounded ascending set of distinct signed keys
// Search, insert, remove and change of keys held in a row of compare cells.
// ---------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one item: func, key and new_key. Each item
//   gives exactly one result item on out_valid/out_ready: a status code and
//   the number of keys held after the operation.
//   Steps: search, insert and remove end in the lookup step, which loads
//   the result; a change refused for an absent old key ends there too, a
//   change refused for a held new key ends in the new-key check, and a
//   change that moves the key passes the check, remove and insert steps.
//   All cells compare against the probe key at once, so the steps do not
//   depend on CAPACITY; the sequencer handles one item at a time, and
//   in_ready is high again in the cycle the result is registered. A result
//   waits in the output register while the receiver stalls; the next item
//   is accepted meanwhile, and its final step holds until the output register is free.
//   Reset empties the set at once; cell contents are not cleared, only the
//   fill count, so no clearing pass is needed.
// ---------------------------------------------------------------------------
module sorted_unique_key_set_top #(
  parameter int CAPACITY  = suks_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH = suks_pkg::KEY_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  suks_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output suks_pkg::out_item_t out_item
);

  suks_pkg::dp_cmd_t  cmd;
  suks_pkg::dp_stat_t stat;

  suks_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  suks_dp #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // Only one item is in work at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item accepted while another was in work");

  // A result is only produced by an item in work.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result produced with no item in work");

  // A full report always comes with the store at capacity.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == suks_pkg::ST_FULL)
      |-> (out_item.entry_count == suks_pkg::ENTRY_W'(CAPACITY)))
    else $error("full status with store below capacity");

endmodule
